/* hdl/dtf_pkg.sv */
// Shared widths, types and the fraction weight table for the decimal text parser.
`default_nettype none
package dtf_pkg;

    localparam int INT_BITS   = 32;
    localparam int FRAC_BITS  = 32;
    localparam int GUARD_BITS = 8;
    localparam int VALUE_W    = 64;

    // fraction accumulator carries guard bits below the output format
    localparam int ACC_W      = FRAC_BITS + GUARD_BITS;
    // integer accumulator never exceeds 2^(INT_BITS-1)-1
    localparam int INT_ACC_W  = INT_BITS - 1;

    // weight table depth; weights are zero long before the last entry
    localparam int FDIG_N     = 32;
    localparam int FDIG_W     = $clog2(FDIG_N);

    typedef logic [ACC_W-1:0]     weight_t;
    typedef weight_t              weight_tab_t [FDIG_N];
    typedef logic [INT_ACC_W-1:0] int_acc_t;
    typedef logic [ACC_W-1:0]     frac_acc_t;
    typedef logic [FDIG_W-1:0]    fdig_cnt_t;

    // finished parse, handed from the scanner to the output stage
    typedef struct packed {
        int_acc_t  int_part;
        frac_acc_t frac_part;
        logic      negative;
        logic      overflow;
    } scan_result_t;

    // weight of fraction digit k: floor(2^ACC_W / 10^(k+1))
    function automatic weight_tab_t build_weights();
        weight_tab_t tab;
        logic [63:0] w;
        w = 64'(1) << ACC_W;
        for (int k = 0; k < FDIG_N; k++)
        begin
            w = w / 64'd10;
            tab[k] = ACC_W'(w);
        end
        return tab;
    endfunction

    localparam weight_tab_t WEIGHT_TAB = build_weights();

endpackage
`default_nettype wire

/* hdl/dtf_scan.sv */
// Byte scanner: sign, integer and fraction accumulation, and the finished-parse register.
`default_nettype none
module dtf_scan
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            text,
    input  wire logic                  eos,
    input  wire logic                  fin_take,
    output logic                       fin_valid,
    output dtf_pkg::scan_result_t      fin
);
    import dtf_pkg::*;

    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam int INT_NEXT_W = INT_BITS + 3;
    localparam int PROD_W     = ACC_W + 4;
    localparam int_acc_t INT_LIMIT = {INT_ACC_W{1'b1}};

    logic [1:0]   phase_reg, phase_next;
    logic [7:0]   prev_reg, prev_next;
    logic         neg_reg, neg_next;
    logic         ovf_reg, ovf_next;
    int_acc_t     int_reg, int_next;
    frac_acc_t    frac_reg, frac_next;
    fdig_cnt_t    cnt_reg, cnt_next;
    logic         fin_valid_reg, fin_valid_next;
    scan_result_t fin_reg, fin_next;

    logic                  is_digit;
    logic                  is_skip;
    logic [3:0]            digit;
    logic [INT_NEXT_W-1:0] int_sum;
    logic [PROD_W-1:0]     frac_prod;
    int_acc_t              int_add;
    logic                  ovf_add;
    frac_acc_t             frac_add;
    fdig_cnt_t             cnt_add;

    assign is_digit = (text >= CH_ZERO) && (text <= CH_NINE);
    assign is_skip  = (text == CH_SPACE) || (text == CH_PLUS) ||
                      (text == CH_MINUS) || (text == CH_DOT);
    assign digit    = 4'(text - CH_ZERO);

    // acc*10 + d as two shifts and adds
    assign int_sum   = (INT_NEXT_W'(int_reg) << 3) + (INT_NEXT_W'(int_reg) << 1)
                     + INT_NEXT_W'(digit);
    assign frac_prod = PROD_W'(digit) * PROD_W'(WEIGHT_TAB[cnt_reg]);

    always_comb
    begin
        int_add = int_reg;
        ovf_add = ovf_reg;
        if (!ovf_reg)
        begin
            if (int_sum > INT_NEXT_W'(INT_LIMIT))
            begin
                int_add = INT_LIMIT;
                ovf_add = 1'b1;
            end
            else
            begin
                int_add = int_acc_t'(int_sum);
            end
        end
        frac_add = frac_reg + frac_prod[ACC_W-1:0];
        cnt_add  = (cnt_reg == fdig_cnt_t'(FDIG_N - 1)) ? cnt_reg : cnt_reg + 1'b1;
    end

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        case (phase_reg)
            PH_SKIP:
            begin
                if (is_skip)
                begin
                    prev_next = text;
                end
                else if (is_digit)
                begin
                    neg_next = (prev_reg == CH_MINUS);
                    if (prev_reg == CH_DOT)
                    begin
                        phase_next = PH_FRAC;
                        frac_next  = frac_add;
                        cnt_next   = cnt_add;
                    end
                    else
                    begin
                        phase_next = PH_INT;
                        int_next   = int_add;
                        ovf_next   = ovf_add;
                    end
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            PH_INT:
            begin
                if (is_digit)
                begin
                    int_next = int_add;
                    ovf_next = ovf_add;
                end
                else if (text == CH_DOT)
                begin
                    phase_next = PH_FRAC;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    frac_next = frac_add;
                    cnt_next  = cnt_add;
                end
                else
                begin
                    phase_next = PH_STOP;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        fin_next.int_part  = int_next;
        fin_next.frac_part = frac_next;
        fin_next.negative  = neg_next;
        fin_next.overflow  = ovf_next;
        if (step && eos)
            fin_valid_next = 1'b1;
        else if (fin_take)
            fin_valid_next = 1'b0;
        else
            fin_valid_next = fin_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            prev_reg      <= '0;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            if (step)
            begin
                if (eos)
                begin
                    // last byte: parse state goes back to its start values
                    phase_reg <= PH_SKIP;
                    prev_reg  <= '0;
                    neg_reg   <= 1'b0;
                    ovf_reg   <= 1'b0;
                    int_reg   <= '0;
                    frac_reg  <= '0;
                    cnt_reg   <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    prev_reg  <= prev_next;
                    neg_reg   <= neg_next;
                    ovf_reg   <= ovf_next;
                    int_reg   <= int_next;
                    frac_reg  <= frac_next;
                    cnt_reg   <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && eos)
            fin_reg <= fin_next;
    end

    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

endmodule
`default_nettype wire

/* hdl/dtf_format.sv */
// Output stage: builds the signed fixed-point word and holds it for the consumer.
`default_nettype none
module dtf_format
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fin_valid,
    input  wire dtf_pkg::scan_result_t        fin,
    input  wire logic                         out_stall,
    output logic                              fin_take,
    output logic                              out_valid,
    output logic signed [dtf_pkg::VALUE_W-1:0] value,
    output logic                              saturated
);
    import dtf_pkg::*;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic                 sat_reg;
    logic [FRAC_BITS-1:0] frac_out;
    logic [VALUE_W-1:0]   mag;

    // overflow forces the largest fraction; otherwise drop the guard bits
    assign frac_out = fin.overflow ? {FRAC_BITS{1'b1}} : fin.frac_part[ACC_W-1:GUARD_BITS];
    assign mag      = (VALUE_W'(fin.int_part) << FRAC_BITS) | VALUE_W'(frac_out);
    assign value_next = fin.negative ? (VALUE_W'(0) - mag) : mag;

    assign fin_take = fin_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (fin_take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fin_take)
        begin
            value_reg <= value_next;
            sat_reg   <= fin.overflow;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule
`default_nettype wire

/* hdl/decimal_text_to_fixed_point_core.sv */
// Top level of the decimal text to signed fixed-point parser.
// A result passes the input register, the parse holding slot and the output register.
// Throughput: one byte per cycle; bytes keep flowing while a result waits on out_stall.
// Input stalls only when an end byte waits, the parse holding slot is full, and the
// output register is held by out_stall.
// Reset (rst_n low, async) clears all valid flags and the parse state.
`default_nettype none
module decimal_text_to_fixed_point_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel: one text byte per request
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    text_byte,
    input  wire logic                          end_of_string,
    // result channel: one number per string
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [dtf_pkg::VALUE_W-1:0] value,
    output logic                               saturated
);
    import dtf_pkg::*;

    // input register stage
    logic         s0_valid_reg, s0_valid_next;
    logic [7:0]   s0_byte_reg;
    logic         s0_eos_reg;

    logic         in_accept;
    logic         scan_step;
    logic         fin_valid;
    logic         fin_take;
    logic         fin_free;
    scan_result_t fin;

    // The holding slot frees up when empty or being drained this cycle.
    assign fin_free  = !fin_valid || fin_take;
    // Ordinary bytes always advance; an end byte needs a free slot for its result.
    assign scan_step = s0_valid_reg && (!s0_eos_reg || fin_free);
    assign in_stall  = s0_valid_reg && !scan_step;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            s0_valid_next = 1'b1;
        else if (scan_step)
            s0_valid_next = 1'b0;
        else
            s0_valid_next = s0_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else
            s0_valid_reg <= s0_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s0_byte_reg <= text_byte;
            s0_eos_reg  <= end_of_string;
        end
    end

    // sign / integer / fraction scan, one byte per cycle while the input is not stalled
    dtf_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (scan_step),
        .text      (s0_byte_reg),
        .eos       (s0_eos_reg),
        .fin_take  (fin_take),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    // assemble, negate and register the result
    dtf_format u_format
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .out_stall (out_stall),
        .fin_take  (fin_take),
        .out_valid (out_valid),
        .value     (value),
        .saturated (saturated)
    );

endmodule
`default_nettype wire

/* hdl/dtf_checker.sv */
// Port-level checker for the parser core and its bind.
`default_nettype none
module dtf_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic [7:0]         text_byte,
    input wire logic               end_of_string,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [63:0] value,
    input wire logic               saturated
);

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(saturated))
        else $error("result changed while stalled");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // a clamped result is the largest magnitude, either sign
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            value == 64'sh7FFF_FFFF_FFFF_FFFF || value == 64'sh8000_0000_0000_0001)
        else $error("saturated result has wrong value");

    // reset empties the result register by the next edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind decimal_text_to_fixed_point_core dtf_checker u_dtf_checker (.*);
`default_nettype wire

/* tb/tb_decimal_text_to_fixed_point_core.sv */
// Self-checking testbench for decimal_text_to_fixed_point_core: text requests in, fixed-point numbers out.
`default_nettype none
module tb_decimal_text_to_fixed_point_core;

    import dtf_pkg::*;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] LEAD_CHARS [4] = '{CH_SPACE, CH_PLUS, CH_MINUS, CH_DOT};

    // largest integer part before clamping, and the first fraction digit weight
    localparam logic [63:0] INT_CEIL    = (64'd1 << (INT_BITS - 1)) - 64'd1;
    localparam logic [63:0] WEIGHT_INIT = (64'd1 << ACC_W) / 64'd10;
    localparam logic [63:0] FRAC_ONES   = (64'd1 << FRAC_BITS) - 64'd1;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_MAX    = 10;
    // settling margin after the last number drains, before the summary
    localparam int SETTLE      = 10;

    typedef enum logic [1:0] {SCAN_LEAD, SCAN_INT, SCAN_FRAC, SCAN_DONE} scan_phase_t;

    typedef struct packed {
        logic [63:0] number;
        logic        clamped;
    } parsed_number_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte     = 8'h00;
    logic        end_of_string = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic signed [VALUE_W-1:0] value;
    logic        saturated;

    decimal_text_to_fixed_point_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .saturated     (saturated)
    );

    // ------------------------------------------------------------------
    // Parser mirror: tracks the scan as each request is accepted.
    // ------------------------------------------------------------------
    scan_phase_t  phase;
    logic [7:0]   lead_byte;     // last skipped byte before the first digit
    logic         is_negative;
    logic         is_clamped;
    logic [63:0]  int_sum;
    logic [63:0]  frac_sum;      // carries GUARD_BITS below the output format
    logic [63:0]  frac_weight;

    parsed_number_t awaited_numbers [$];

    // bookkeeping
    int errors;
    int cycles;
    int requests_sent;
    int strings_sent;
    int numbers_checked;
    int clamped_seen;

    // idling controls: sender gaps and receiver stalls only while enabled
    bit idle_on;
    bit calm_string;             // one string sent without sender gaps
    int stall_left;

    logic [7:0] chars_q [$];     // string under construction

    task automatic parser_clear();
        phase       = SCAN_LEAD;
        lead_byte   = CH_NUL;
        is_negative = 1'b0;
        is_clamped  = 1'b0;
        int_sum     = '0;
        frac_sum    = '0;
        frac_weight = WEIGHT_INIT;
    endtask

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic push_int_digit(input logic [7:0] c);
        logic [63:0] next;
        // once clamped, later digits are dropped
        if (!is_clamped)
        begin
            next = int_sum * 64'd10 + 64'(c - CH_ZERO);
            if (next > INT_CEIL)
            begin
                int_sum    = INT_CEIL;
                is_clamped = 1'b1;
            end
            else
                int_sum = next;
        end
    endtask

    task automatic push_frac_digit(input logic [7:0] c);
        frac_sum    = frac_sum + 64'(c - CH_ZERO) * frac_weight;
        frac_weight = frac_weight / 64'd10;
    endtask

    // Advance the mirror by one accepted request; queue the number on the last byte.
    task automatic parser_take(input logic [7:0] c, input logic last);
        logic [63:0]    frac;
        logic [63:0]    mag;
        parsed_number_t res;
        case (phase)
            SCAN_LEAD:
                if (c == CH_SPACE || c == CH_PLUS || c == CH_MINUS || c == CH_DOT)
                    lead_byte = c;
                else if (is_digit(c))
                begin
                    // sign and fraction-only mode come from the byte just before
                    is_negative = (lead_byte == CH_MINUS);
                    if (lead_byte == CH_DOT)
                    begin
                        phase = SCAN_FRAC;
                        push_frac_digit(c);
                    end
                    else
                    begin
                        phase = SCAN_INT;
                        push_int_digit(c);
                    end
                end
                else
                    phase = SCAN_DONE;
            SCAN_INT:
                if (is_digit(c))
                    push_int_digit(c);
                else if (c == CH_DOT)
                    phase = SCAN_FRAC;
                else
                    phase = SCAN_DONE;
            SCAN_FRAC:
                if (is_digit(c))
                    push_frac_digit(c);
                else
                    phase = SCAN_DONE;
            default: ;
        endcase
        if (last)
        begin
            frac = is_clamped ? FRAC_ONES : (frac_sum >> GUARD_BITS);
            mag  = (int_sum << FRAC_BITS) | frac;
            res.number  = is_negative ? (64'd0 - mag) : mag;
            res.clamped = is_clamped;
            awaited_numbers.push_back(res);
            parser_clear();
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: drive on the falling edge, accept on the rising edge.
    // in_valid gets at most one assignment per falling edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        if (idle_on && !calm_string && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        in_valid      <= 1'b1;
        text_byte     <= c;
        end_of_string <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        parser_take(c, last);
        requests_sent++;
    endtask

    task automatic send_chars();
        foreach (chars_q[i])
            send_byte(chars_q[i], i == chars_q.size() - 1);
        strings_sent++;
    endtask

    task automatic load_text(input string s);
        chars_q.delete();
        for (int i = 0; i < s.len(); i++)
            chars_q.push_back(s[i]);
    endtask

    // Mostly well-formed numbers with random content; some broken, some pure noise.
    task automatic build_string();
        int kind;
        int n_lead;
        int n_int;
        int n_frac;
        int n_junk;
        kind = $urandom_range(0, 9);
        chars_q.delete();
        if (kind >= 8)
        begin
            // noise: arbitrary bytes, any value
            n_junk = $urandom_range(1, 6);
            repeat (n_junk) chars_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n_lead = $urandom_range(0, 3);
        repeat (n_lead) chars_q.push_back(LEAD_CHARS[$urandom_range(0, 3)]);
        // occasional long integer part to push into saturation
        n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
        repeat (n_int) chars_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1) == 1)
        begin
            chars_q.push_back(CH_DOT);
            // now and then run the fraction weight down to zero
            n_frac = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18)
                                                 : $urandom_range(0, 5);
            repeat (n_frac) chars_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 2) == 0)
        begin
            // terminator followed by bytes that must be ignored
            chars_q.push_back($urandom_range(0, 1) ? CH_NUL : 8'($urandom_range(0, 255)));
            n_junk = $urandom_range(0, 2);
            repeat (n_junk) chars_q.push_back(8'($urandom_range(0, 255)));
        end
        if (chars_q.size() == 0)
            chars_q.push_back(8'($urandom_range(0, 255)));
        // broken: one position overwritten by an arbitrary byte
        if (kind == 7)
            chars_q[$urandom_range(0, chars_q.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic wait_drained();
        while (awaited_numbers.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty string, digit first, minus zero, fraction-only, non-digit first
    // (also the top byte value), skip bytes only, stop with trailing digits.
    task automatic test_edge_strings();
        chars_q = {CH_NUL};
        send_chars();
        load_text("7");
        send_chars();
        load_text("-0");
        send_chars();
        load_text(".5");
        send_chars();
        chars_q = {8'hFF, CH_NINE};
        send_chars();
        load_text(" -");
        send_chars();
        load_text("1.5a7");
        send_chars();
    endtask

    // Integer part beyond the signed limit: clamp, fraction all ones, flag set.
    task automatic test_integer_clamp();
        load_text("-3000000000");
        send_chars();
    endtask

    task automatic test_random_strings(input int n_requests);
        int stop_at;
        stop_at = requests_sent + n_requests;
        while (requests_sent < stop_at)
        begin
            calm_string = ($urandom_range(0, 4) == 0);
            build_string();
            send_chars();
        end
        calm_string = 1'b0;
    endtask

    // Sender holds off until every queued number has come back.
    task automatic test_drain_pause();
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        test_random_strings(20);
    endtask

    // Back-to-back requests and no receiver stalls to close the run.
    task automatic test_steady_tail();
        idle_on = 1'b0;
        test_random_strings(50);
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle guard, receiver stalls, result checker
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_decimal_text_to_fixed_point_core: errors");
            $finish;
        end
    end

    // receiver stalls in bursts of random length while idling is enabled
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 12);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic flag_error(input string what);
        errors++;
        if (errors <= SHOW_MAX)
            $display("%s", what);
    endtask

    always @(posedge clk)
    begin
        parsed_number_t exp_num;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_numbers.size() == 0)
                flag_error($sformatf("unexpected number value=%h saturated=%b",
                                     value, saturated));
            else
            begin
                exp_num = awaited_numbers.pop_front();
                numbers_checked++;
                if (saturated)
                    clamped_seen++;
                if (value !== exp_num.number)
                    flag_error($sformatf("value mismatch: expected %h, got %h",
                                         exp_num.number, value));
                if (saturated !== exp_num.clamped)
                    flag_error($sformatf("saturated mismatch: expected %b, got %b",
                                         exp_num.clamped, saturated));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        errors          = 0;
        cycles          = 0;
        requests_sent   = 0;
        strings_sent    = 0;
        numbers_checked = 0;
        clamped_seen    = 0;
        stall_left      = 0;
        calm_string     = 1'b0;
        idle_on         = 1'b1;
        parser_clear();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_edge_strings();
        test_integer_clamp();
        test_random_strings(160);
        test_drain_pause();
        test_random_strings(150);
        test_steady_tail();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d strings in %0d requests; %0d numbers checked, %0d of them clamped.",
                 strings_sent, requests_sent, numbers_checked, clamped_seen);
        if (errors == 0 && awaited_numbers.size() == 0)
            $display("tb_decimal_text_to_fixed_point_core: clean");
        else
            $display("tb_decimal_text_to_fixed_point_core: errors");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
hdl/dtf_pkg.sv
hdl/dtf_scan.sv
hdl/dtf_format.sv
hdl/decimal_text_to_fixed_point_core.sv
hdl/dtf_checker.sv
tb/tb_decimal_text_to_fixed_point_core.sv
